// ----- rtl/crv_pkg.sv -----
package crv_pkg;

	localparam int unsigned DATA_W    = 8;
	localparam int unsigned LEN_W     = 13;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [LEN_W-1:0] CAPACITY_RESET = 13'd4096;

	// register index, taken from paddr above the byte lane bits
	typedef enum logic [APB_ADDR_W-3:0] {
		REG_CAPACITY   = 1'b0,
		REG_SIZE_QUERY = 1'b1
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_CORRUPT     = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FAULT_NONE   = 2'd0,
		FAULT_MAGIC  = 2'd1,
		FAULT_FORMAT = 2'd2
	} fault_t;

	typedef struct packed {
		logic [LEN_W-1:0] capacity_limit;
		logic             size_query_mode;
	} cfg_t;

endpackage

// ----- rtl/crv_stream_if.sv -----
interface crv_in_if;
	logic                         valid;
	logic                         ready;
	logic [crv_pkg::DATA_W-1:0]   data_byte;
	logic                         end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface crv_out_if;
	logic                         valid;
	logic                         ready;
	logic                         byte_present;
	logic [crv_pkg::DATA_W-1:0]   payload_byte;
	logic                         verdict_present;
	logic [crv_pkg::STATUS_W-1:0] status;
	logic [crv_pkg::LEN_W-1:0]    record_length;

	modport source (output valid, output byte_present, output payload_byte,
		output verdict_present, output status, output record_length, input ready);
	modport sink   (input valid, input byte_present, input payload_byte,
		input verdict_present, input status, input record_length, output ready);
endinterface

// ----- rtl/crv_cfg_regs.sv -----
module crv_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [crv_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [crv_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [crv_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output crv_pkg::cfg_t                    cfg
);
	import crv_pkg::*;

	logic [LEN_W-1:0] capacity_q;
	logic             size_query_q;
	reg_idx_t         idx;
	logic             wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RESET;
			size_query_q <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_CAPACITY:   capacity_q   <= pwdata[LEN_W-1:0];
				REG_SIZE_QUERY: size_query_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CAPACITY:   prdata = {{(APB_DATA_W-LEN_W){1'b0}}, capacity_q};
			REG_SIZE_QUERY: prdata = {{(APB_DATA_W-1){1'b0}}, size_query_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.capacity_limit  = capacity_q;
	assign cfg.size_query_mode = size_query_q;

endmodule

// ----- rtl/crc_record_validator_unit.sv -----
// crc_record_validator_unit
// checks one stored record that arrives a byte per item on in_ch, the last
// byte flagged by end_of_file. the 16-byte header holds the magic, a format
// byte, a little-endian payload length and a little-endian reflected crc-32
// of the payload. payload bytes leave on out_ch as they arrive (none in
// size-query mode); the end-of-file item also carries the verdict, and the
// consumer drops the payload unless status is ok. bytes that give no payload
// and no verdict produce no output item.
// throughput: one item per cycle while out_ch does not stall, set by the
// byte-wide crc update between the input register and the result register.
// an accepted item is held in the input register, then in the result register
// that drives out_ch. when out_ch stalls, the result register holds, the input
// register fills and then in_ch.ready falls; nothing is lost.
// reset (arst_n low) empties both registers, starts a new file and sets
// capacity_limit to 4096 and size_query_mode to 0. the registers are written
// over the apb port (capacity at 0x0, size query at 0x4); the user writes them
// only while idle, and the block itself does not enforce this.
module crc_record_validator_unit #(
	parameter int unsigned MAX_RECORD = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	crv_in_if.sink                           in_ch,
	crv_out_if.source                        out_ch,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [crv_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [crv_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [crv_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import crv_pkg::*;

	localparam int unsigned HDR   = 16;
	localparam int unsigned SAT   = HDR + MAX_RECORD + 1;
	localparam int unsigned POS_W = $clog2(SAT + 1);
	localparam logic [31:0] POLY  = 32'hEDB88320;
	localparam logic [7:0]  FORMAT_BYTE = 8'd1;
	localparam logic [31:0] MAGIC = {8'h44, 8'h53, 8'h48, 8'h54};

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (POLY & {32{r[0]}});
		end
		return r;
	endfunction

	cfg_t cfg;

	crv_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eof_s1;
	logic             advance;

	// per-file state
	logic [POS_W-1:0] pos_q;
	fault_t           fault_q;
	logic [31:0]      length_q;
	logic [31:0]      stored_q;
	logic [31:0]      crc_q;

	// result register
	logic             out_valid_q;
	logic             byte_present_q;
	logic [7:0]       payload_q;
	logic             verdict_q;
	status_t          status_q;
	logic [LEN_W-1:0] rlen_q;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			eof_s1  <= in_ch.end_of_file;
		end
	end

	// next state for the item in the input register
	logic [POS_W-1:0] pos_d;
	fault_t           fault_d;
	logic [31:0]      length_d;
	logic [31:0]      stored_d;
	logic [31:0]      crc_d;
	logic [POS_W-1:0] offset;
	logic             byte_out;
	status_t          status_d;
	logic [LEN_W-1:0] rlen_d;
	logic             len_bad;

	assign offset = pos_q - POS_W'(HDR);

	always_comb begin
		fault_d  = fault_q;
		length_d = length_q;
		stored_d = stored_q;
		crc_d    = crc_q;
		byte_out = 1'b0;
		if (pos_q < POS_W'(4)) begin
			if (byte_s1 != MAGIC[8*pos_q[1:0] +: 8]) begin
				fault_d = FAULT_MAGIC;
			end
		end else if (pos_q == POS_W'(4)) begin
			if (byte_s1 != FORMAT_BYTE && fault_q == FAULT_NONE) begin
				fault_d = FAULT_FORMAT;
			end
		end else if (pos_q >= POS_W'(8) && pos_q < POS_W'(12)) begin
			length_d[8*pos_q[1:0] +: 8] = byte_s1;
		end else if (pos_q >= POS_W'(12) && pos_q < POS_W'(HDR)) begin
			stored_d[8*pos_q[1:0] +: 8] = byte_s1;
		end else if (pos_q >= POS_W'(HDR) && pos_q < POS_W'(SAT)) begin
			crc_d    = crc_byte(crc_q, byte_s1);
			byte_out = (32'(offset) < length_q) && !cfg.size_query_mode;
		end
		pos_d = (pos_q < POS_W'(SAT)) ? pos_q + POS_W'(1) : pos_q;
	end

	// verdict on the end-of-file byte
	assign len_bad = (length_d == 32'd0) || (length_d > 32'(MAX_RECORD)) ||
		(32'(pos_d) != length_d + 32'(HDR)) || ((crc_d ^ 32'hFFFFFFFF) != stored_d);

	always_comb begin
		status_d = ST_OK;
		rlen_d   = '0;
		if (pos_d < POS_W'(HDR) || fault_d == FAULT_MAGIC) begin
			status_d = ST_CORRUPT;
		end else if (fault_d == FAULT_FORMAT) begin
			status_d = ST_UNSUPPORTED;
		end else if (len_bad) begin
			status_d = ST_CORRUPT;
		end else begin
			rlen_d = length_d[LEN_W-1:0];
			if (!cfg.size_query_mode && length_d > 32'(cfg.capacity_limit)) begin
				status_d = ST_CORRUPT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fault_q  <= FAULT_NONE;
			length_q <= '0;
			stored_q <= '0;
			crc_q    <= 32'hFFFFFFFF;
		end else if (advance) begin
			if (eof_s1) begin
				pos_q    <= '0;
				fault_q  <= FAULT_NONE;
				length_q <= '0;
				stored_q <= '0;
				crc_q    <= 32'hFFFFFFFF;
			end else begin
				pos_q    <= pos_d;
				fault_q  <= fault_d;
				length_q <= length_d;
				stored_q <= stored_d;
				crc_q    <= crc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= byte_out || eof_s1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_present_q <= byte_out;
			payload_q      <= byte_out ? byte_s1 : 8'd0;
			verdict_q      <= eof_s1;
			status_q       <= eof_s1 ? status_d : ST_OK;
			rlen_q         <= eof_s1 ? rlen_d : '0;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.byte_present    = byte_present_q;
	assign out_ch.payload_byte    = payload_q;
	assign out_ch.verdict_present = verdict_q;
	assign out_ch.status          = status_q;
	assign out_ch.record_length   = rlen_q;

endmodule

// ----- sim/crc_record_validator_checker.sv -----
`timescale 1ns / 1ps

module crc_record_validator_checker #(
	parameter int unsigned MAX_RECORD = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	crv_in_if                              in_ch,
	crv_out_if                             out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [crv_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [crv_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [crv_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             outstanding
);
	import crv_pkg::*;

	localparam int unsigned HDR_BYTES = 16;
	localparam int unsigned FORMAT_AT = 4;
	localparam int unsigned LENGTH_AT = 8;
	localparam int unsigned CRC_AT    = 12;
	localparam int unsigned POS_SAT   = HDR_BYTES + MAX_RECORD + 1;
	localparam logic [7:0]  FORMAT_ID = 8'd1;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	// magic bytes, first byte in the low lane
	localparam logic [31:0] MAGIC_WORD = 32'h44534854;

	typedef struct packed {
		logic             byte_present;
		logic [7:0]       payload_byte;
		logic             verdict_present;
		status_t          status;
		logic [LEN_W-1:0] record_length;
	} record_output_t;

	logic [LEN_W-1:0] capacity_limit;
	logic             size_query;
	int unsigned      file_pos;
	fault_t           header_fault;
	logic [31:0]      header_length;
	logic [31:0]      header_crc;
	logic [31:0]      payload_crc;
	record_output_t   outputs_due[$];
	record_output_t   oldest;
	int               fails = 0;

	assign fail_count = fails;

	function automatic logic [31:0] crc32_feed(logic [31:0] crc, logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++)
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	task automatic start_file();
		file_pos = 0;
		header_fault = FAULT_NONE;
		header_length = '0;
		header_crc = '0;
		payload_crc = '1;
	endtask

	task automatic advance_record(input logic [7:0] data, input logic last);
		record_output_t res;
		logic emit;
		int unsigned pos;
		logic [31:0] rlen;
		pos = file_pos;
		emit = 1'b0;
		res = '0;
		rlen = '0;
		if (pos < FORMAT_AT) begin
			if (data != MAGIC_WORD[8*pos +: 8])
				header_fault = FAULT_MAGIC;
		end else if (pos == FORMAT_AT) begin
			if (data != FORMAT_ID && header_fault == FAULT_NONE)
				header_fault = FAULT_FORMAT;
		end else if (pos >= LENGTH_AT && pos < LENGTH_AT + 4) begin
			header_length = header_length | ({24'd0, data} << (8 * (pos - LENGTH_AT)));
		end else if (pos >= CRC_AT && pos < CRC_AT + 4) begin
			header_crc = header_crc | ({24'd0, data} << (8 * (pos - CRC_AT)));
		end else if (pos >= HDR_BYTES && pos < POS_SAT) begin
			payload_crc = crc32_feed(payload_crc, data);
			if ((pos - HDR_BYTES) < header_length && !size_query)
				emit = 1'b1;
		end
		if (pos < POS_SAT)
			file_pos = pos + 1;
		if (emit) begin
			res.byte_present = 1'b1;
			res.payload_byte = data;
		end
		if (last) begin
			res.verdict_present = 1'b1;
			res.status = ST_OK;
			if (file_pos < HDR_BYTES || header_fault == FAULT_MAGIC) begin
				res.status = ST_CORRUPT;
			end else if (header_fault == FAULT_FORMAT) begin
				res.status = ST_UNSUPPORTED;
			end else if (header_length == 0 || header_length > MAX_RECORD ||
					file_pos != HDR_BYTES + header_length ||
					~payload_crc != header_crc) begin
				res.status = ST_CORRUPT;
			end else begin
				rlen = header_length;
				// over capacity still reports the length
				if (!size_query && header_length > capacity_limit)
					res.status = ST_CORRUPT;
			end
			res.record_length = rlen[LEN_W-1:0];
			start_file();
		end
		if (emit || last)
			outputs_due.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_limit = CAPACITY_RESET;
			size_query = 1'b0;
			start_file();
			outputs_due.delete();
			outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (outputs_due.size() == 0) begin
					report_mismatch("unexpected item", 32'({out_ch.verdict_present,
						out_ch.byte_present, out_ch.payload_byte}), 32'd0);
				end else begin
					oldest = outputs_due.pop_front();
					if (out_ch.byte_present !== oldest.byte_present)
						report_mismatch("byte_present", 32'(out_ch.byte_present),
							32'(oldest.byte_present));
					if (out_ch.payload_byte !== oldest.payload_byte)
						report_mismatch("payload_byte", 32'(out_ch.payload_byte),
							32'(oldest.payload_byte));
					if (out_ch.verdict_present !== oldest.verdict_present)
						report_mismatch("verdict_present", 32'(out_ch.verdict_present),
							32'(oldest.verdict_present));
					if (out_ch.status !== oldest.status)
						report_mismatch("status", 32'(out_ch.status), 32'(oldest.status));
					if (out_ch.record_length !== oldest.record_length)
						report_mismatch("record_length", 32'(out_ch.record_length),
							32'(oldest.record_length));
				end
			end
			if (in_ch.valid && in_ch.ready)
				advance_record(in_ch.data_byte, in_ch.end_of_file);
			if (psel && penable && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_CAPACITY: begin
						if (pwrite)
							capacity_limit = pwdata[LEN_W-1:0];
						else if (prdata !== 32'(capacity_limit))
							report_mismatch("capacity_limit read", prdata,
								32'(capacity_limit));
					end
					REG_SIZE_QUERY: begin
						if (pwrite)
							size_query = pwdata[0];
						else if (prdata !== 32'(size_query))
							report_mismatch("size_query_mode read", prdata,
								32'(size_query));
					end
					default: ;
				endcase
			end
			outstanding <= outputs_due.size();
		end
	end

endmodule

// ----- sim/crc_record_validator_unit_test.sv -----
`timescale 1ns / 1ps

module crc_record_validator_unit_test;
	import crv_pkg::*;

	localparam int unsigned MAX_RECORD   = 4096;
	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned RUN_LIMIT    = 4000000;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned CRC_AT       = 12;
	localparam logic [7:0]  FORMAT_ID    = 8'd1;
	localparam logic [31:0] MAGIC_WORD   = 32'h44534854;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    outstanding;
	int                    hold_requests = 0;
	int                    holds_served = 0;
	int unsigned           sent_items = 0;
	bit                    dense_send = 1'b0;
	logic [7:0]            file_bytes[$];

	crv_in_if  in_ch();
	crv_out_if out_ch();

	crc_record_validator_unit #(
		.MAX_RECORD(MAX_RECORD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	crc_record_validator_checker #(
		.MAX_RECORD(MAX_RECORD)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// consumer side: random back-pressure, plus long hold-offs on request
	initial begin : consumer
		int r;
		int n;
		logic v;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				v = 1'b0;
				n = HOLD_CYCLES;
				holds_served++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					v = 1'b1;
					n = $urandom_range(1, 40);
				end else if (r < 95) begin
					v = 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					v = 1'b0;
					n = $urandom_range(10, 40);
				end
			end
			out_ch.ready <= v;
			repeat (n) @(posedge clk);
		end
	end

	function automatic logic [31:0] crc32_feed(logic [31:0] crc, logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++)
			c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic last);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = 0;
		if (!dense_send) begin
			if (r >= 94)
				gap = $urandom_range(8, 30);
			else if (r >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= data;
		in_ch.end_of_file <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_items++;
	endtask

	task automatic send_file();
		int k;
		for (k = 0; k < file_bytes.size(); k++)
			send_byte(file_bytes[k], k == file_bytes.size() - 1);
	endtask

	// well-formed unless hdr_len differs or good_crc is 0; callers damage it afterwards
	task automatic build_record(input int unsigned body_len, input logic [31:0] hdr_len,
			input bit good_crc);
		logic [31:0] crc;
		logic [7:0] b;
		int k;
		crc = '1;
		file_bytes.delete();
		for (k = 0; k < 4; k++)
			file_bytes.push_back(MAGIC_WORD[8*k +: 8]);
		file_bytes.push_back(FORMAT_ID);
		repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
		for (k = 0; k < 4; k++)
			file_bytes.push_back(hdr_len[8*k +: 8]);
		repeat (4) file_bytes.push_back(8'd0);
		repeat (body_len) begin
			b = 8'($urandom_range(0, 255));
			crc = crc32_feed(crc, b);
			file_bytes.push_back(b);
		end
		crc = ~crc;
		if (!good_crc)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (k = 0; k < 4; k++)
			file_bytes[CRC_AT + k] = crc[8*k +: 8];
	endtask

	task automatic apb_access(input bit wr, input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wr ? value : 32'd0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// bytes with no output may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [LEN_W-1:0] capacity, input logic query);
		drain_results();
		apb_access(1'b1, REG_CAPACITY, 32'(capacity));
		apb_access(1'b0, REG_CAPACITY, 32'd0);
		apb_access(1'b1, REG_SIZE_QUERY, 32'(query));
		apb_access(1'b0, REG_SIZE_QUERY, 32'd0);
	endtask

	task automatic random_record(input logic [LEN_W-1:0] capacity);
		int r;
		int len;
		int k;
		r = $urandom_range(0, 99);
		len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(25, 300))
			: int'($urandom_range(1, 24));
		if (r < 55) begin
			build_record(len, len, 1'b1);
		end else if (r < 60) begin
			// bad magic, sometimes with a bad format too
			build_record(len, len, 1'b1);
			k = $urandom_range(0, 3);
			file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
			if ($urandom_range(0, 1))
				file_bytes[4] = 8'($urandom_range(2, 255));
		end else if (r < 65) begin
			build_record(len, len, 1'b1);
			file_bytes[4] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(2, 255));
		end else if (r < 68) begin
			build_record($urandom_range(0, 1) ? 0 : $urandom_range(1, 4), 32'd0, 1'b1);
		end else if (r < 72) begin
			k = $urandom_range(0, 2);
			if (k == 0)
				build_record(len, 32'(MAX_RECORD + 1), 1'b1);
			else if (k == 1)
				build_record(len, 32'hFFFFFFFF, 1'b1);
			else
				build_record(len, $urandom_range(MAX_RECORD + 1, 32'hFFFFFFFF), 1'b1);
		end else if (r < 78) begin
			// file size disagrees with the header length
			if ($urandom_range(0, 1)) begin
				build_record(len + int'($urandom_range(1, 5)), len, 1'b1);
			end else begin
				build_record(len, len, 1'b1);
				k = $urandom_range(1, len);
				repeat (k) void'(file_bytes.pop_back());
			end
		end else if (r < 84) begin
			build_record(len, len, 1'b0);
		end else if (r < 90) begin
			build_record(1, 1, 1'b1);
			k = $urandom_range(1, 15);
			while (file_bytes.size() > k) void'(file_bytes.pop_back());
		end else if (r < 95) begin
			file_bytes.delete();
			repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// lengths around the capacity, random up to 300 when that is above 300
			len = int'(capacity) + int'($urandom_range(0, 2)) - 1;
			if (len < 1)
				len = 1;
			if (len > 300)
				len = $urandom_range(1, 300);
			build_record(len, len, 1'b1);
		end
		send_file();
	endtask

	initial begin : stimulus
		int phase;
		int unsigned phase_end;
		logic [LEN_W-1:0] capacity;
		logic query;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.end_of_file = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting(CAPACITY_RESET, 1'b0);
		// lone byte, header cut after the format byte, smallest good record
		file_bytes.delete();
		file_bytes.push_back(8'hFF);
		send_file();
		build_record(0, 0, 1'b1);
		while (file_bytes.size() > 5) void'(file_bytes.pop_back());
		send_file();
		build_record(1, 1, 1'b1);
		file_bytes[16] = 8'h00;
		build_record(1, 1, 1'b1);
		send_file();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin capacity = 13'd4096; query = 1'b0; end
				1: begin capacity = 13'd0; query = 1'b0; end
				2: begin capacity = 13'($urandom_range(1, 40)); query = 1'b0; end
				3: begin capacity = 13'd4096; query = 1'b1; end
				4: begin capacity = 13'd0; query = 1'b1; end
				default: begin
					capacity = 13'($urandom_range(0, 4096));
					query = 1'($urandom_range(0, 1));
				end
			endcase
			apply_setting(capacity, query);
			if (phase == 1) begin
				// consumer stalls while a dense record piles up behind it
				hold_requests++;
				dense_send = 1'b1;
				build_record(120, 120, 1'b1);
				send_file();
				dense_send = 1'b0;
			end
			phase_end = sent_items + RANDOM_ITEMS / PHASES;
			while (sent_items < phase_end) begin
				random_record(capacity);
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
